### sv/jdd_pkg.sv
// Shared types and constants for the Julian day number to calendar date unit.
// No dependencies; used by every module of the unit but jdd_cdiv, through scoped names.
package jdd_pkg;

    // Width of the day number field.
    localparam int unsigned DAY_W = 23;

    // First day number converted with the Gregorian rules (15 Oct 1582).
    localparam logic [DAY_W-1:0] SWITCH_DAY = 23'd2299161;

    // Register stages of the calendar-specific front end and the shared back end.
    localparam int unsigned ERA_STAGES   = 6;
    localparam int unsigned MONTH_STAGES = 5;
    localparam int unsigned PIPE_DEPTH   = ERA_STAGES + MONTH_STAGES;

    // Width of the day-of-year offset counted from 1 March (plus 31).
    localparam int unsigned DOY_W = 9;

    // Hand-over from the front end to the month/day back end.
    typedef struct packed {
        logic [DOY_W-1:0] doy;          // day offset within the March-based year
        logic [15:0]      year_base;    // two's complement year before the January carry
        logic [2:0]       weekday;      // 0 = Saturday
        logic             is_gregorian; // calendar that was applied
    } t_era_item;

    // One finished calendar date.
    typedef struct packed {
        logic [15:0] year;              // two's complement, astronomical numbering
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic        is_gregorian;
    } t_date;

endpackage

### sv/jdd_cdiv.sv
// Exact truncating division of an unsigned value by a constant, done as one
// multiplication by a rounded-up reciprocal. No dependencies.
module jdd_cdiv #(
    parameter int unsigned W  = 16,
    parameter int unsigned C  = 3,
    parameter int unsigned QW = 16
) (
    input  logic [W-1:0]  i_x,
    output logic [QW-1:0] o_q
);

    // With K = W + bits(C) the rounding error of the reciprocal stays below 1/C
    // for every W-bit dividend, so the shifted product is the exact quotient.
    localparam int unsigned K      = W + $clog2(C + 1);
    localparam logic [63:0] M_FULL = ((64'd1 << K) + 64'(C) - 64'd1) / 64'(C);
    localparam logic [W+1:0] M     = M_FULL[W+1:0];

    logic [2*W+1:0] prod;

    // Reciprocal multiplication; the quotient sits from bit K upward.
    assign prod = {{(W+2){1'b0}}, i_x} * {{W{1'b0}}, M};
    assign o_q  = prod[K +: QW];

endmodule

### sv/jdd_era.sv
// Front end: reduces a day number to a March-based day offset and a year base,
// by Gregorian or Julian rules, and works out the weekday. Uses jdd_pkg, jdd_cdiv.
module jdd_era (
    input  logic                                i_clk,
    input  logic [jdd_pkg::ERA_STAGES-1:0]      i_ld,
    input  logic [jdd_pkg::DAY_W-1:0]           i_day_number,
    output jdd_pkg::t_era_item                  o_item
);

    // Stage 1 registers
    logic [25:0] r1_x4;
    logic [21:0] r1_js;
    logic [23:0] r1_w;
    logic        r1_greg;
    // Stage 2 registers
    logic [7:0]  r2_cent4;
    logic [10:0] r2_quad;
    logic [20:0] r2_q7;
    logic [23:0] r2_a;
    logic [21:0] r2_js;
    logic [23:0] r2_w;
    logic        r2_greg;
    // Stage 3 registers
    logic [17:0] r3_a2;
    logic [10:0] r3_rem;
    logic [2:0]  r3_wd;
    logic [7:0]  r3_cent4;
    logic [10:0] r3_quad;
    logic        r3_greg;
    // Stage 4 registers
    logic [29:0] r4_y4k;
    logic [17:0] r4_a2;
    logic [8:0]  r4_doy;
    logic [15:0] r4_jy;
    logic [15:0] r4_c100;
    logic [2:0]  r4_wd;
    logic        r4_greg;
    // Stage 5 registers
    logic [8:0]  r5_yr;
    logic [17:0] r5_a2;
    logic [8:0]  r5_doy;
    logic [15:0] r5_jy;
    logic [15:0] r5_c100;
    logic [2:0]  r5_wd;
    logic        r5_greg;
    // Stage 6 register
    jdd_pkg::t_era_item r6_item;

    // Combinational next values
    logic [23:0] n1_a;
    logic [7:0]  n2_cent4;
    logic [10:0] n2_quad;
    logic [20:0] n2_q7;
    logic [25:0] cent_prod;
    logic [23:0] a2_full;
    logic [21:0] quad_prod;
    logic [21:0] rem_full;
    logic [23:0] wd_full;
    logic [17:0] a2_plus1;
    logic [1:0]  yq;
    logic [10:0] doy_full;
    logic [8:0]  n5_yr;
    logic [19:0] yr_prod;
    logic [17:0] a3_full;
    logic [15:0] greg_year;
    jdd_pkg::t_era_item n6_item;

    // Stage 1: offsets for both calendars and the weekday, and the calendar choice.
    assign n1_a = {1'b0, i_day_number} + 24'd68569;

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r1_x4   <= {n1_a, 2'b00};
            r1_js   <= i_day_number[21:0] + 22'd1401;
            r1_w    <= {1'b0, i_day_number} + 24'd2;
            r1_greg <= (i_day_number >= jdd_pkg::SWITCH_DAY);
        end
    end

    // Stage 2: Gregorian 400-year cycles, Julian 4-year cycles and weeks.
    jdd_cdiv #(.W(26), .C(146097), .QW(8)) u_div_cent (
        .i_x (r1_x4),
        .o_q (n2_cent4)
    );

    jdd_cdiv #(.W(22), .C(1461), .QW(11)) u_div_quad (
        .i_x (r1_js),
        .o_q (n2_quad)
    );

    jdd_cdiv #(.W(24), .C(7), .QW(21)) u_div_week (
        .i_x (r1_w),
        .o_q (n2_q7)
    );

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r2_cent4 <= n2_cent4;
            r2_quad  <= n2_quad;
            r2_q7    <= n2_q7;
            r2_a     <= r1_x4[25:2];
            r2_js    <= r1_js;
            r2_w     <= r1_w;
            r2_greg  <= r1_greg;
        end
    end

    // Stage 3: remainders of the cycle divisions.
    assign cent_prod = 26'd146097 * {18'd0, r2_cent4} + 26'd3;
    assign a2_full   = r2_a - cent_prod[25:2];
    assign quad_prod = 22'd1461 * {11'd0, r2_quad};
    assign rem_full  = r2_js + 22'd1 - quad_prod;
    assign wd_full   = r2_w - 24'd7 * {3'd0, r2_q7};

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r3_a2    <= a2_full[17:0];
            r3_rem   <= rem_full[10:0];
            r3_wd    <= wd_full[2:0];
            r3_cent4 <= r2_cent4;
            r3_quad  <= r2_quad;
            r3_greg  <= r2_greg;
        end
    end

    // Stage 4: Julian year within the cycle by threshold compares (the final
    // leap day of a cycle stays in the fourth year), and the Gregorian century base.
    assign a2_plus1 = r3_a2 + 18'd1;
    assign yq       = 2'((r3_rem >= 11'd366) ? 1 : 0) + 2'((r3_rem >= 11'd731) ? 1 : 0)
                    + 2'((r3_rem >= 11'd1096) ? 1 : 0);
    assign doy_full = r3_rem - 11'd365 * {9'd0, yq} + 11'd30;

    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r4_y4k  <= 30'd4000 * {12'd0, a2_plus1};
            r4_a2   <= r3_a2;
            r4_doy  <= doy_full[8:0];
            r4_jy   <= {3'b000, r3_quad, 2'b00} + {14'd0, yq} - 16'd4716;
            r4_c100 <= 16'd100 * ({8'd0, r3_cent4} - 16'd49);
            r4_wd   <= r3_wd;
            r4_greg <= r3_greg;
        end
    end

    // Stage 5: Gregorian year within the 400-year cycle.
    jdd_cdiv #(.W(30), .C(1461001), .QW(9)) u_div_year (
        .i_x (r4_y4k),
        .o_q (n5_yr)
    );

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r5_yr   <= n5_yr;
            r5_a2   <= r4_a2;
            r5_doy  <= r4_doy;
            r5_jy   <= r4_jy;
            r5_c100 <= r4_c100;
            r5_wd   <= r4_wd;
            r5_greg <= r4_greg;
        end
    end

    // Stage 6: Gregorian day offset, then select the calendar that applies.
    assign yr_prod   = 20'd1461 * {11'd0, r5_yr};
    assign a3_full   = r5_a2 - yr_prod[19:2] + 18'd31;
    assign greg_year = r5_c100 + {7'd0, r5_yr};

    always_comb begin
        n6_item.doy          = r5_greg ? a3_full[8:0] : r5_doy;
        n6_item.year_base    = r5_greg ? greg_year : r5_jy;
        n6_item.weekday      = r5_wd;
        n6_item.is_gregorian = r5_greg;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[5]) begin
            r6_item <= n6_item;
        end
    end

    assign o_item = r6_item;

endmodule

### sv/jdd_month.sv
// Back end shared by both calendars: splits the March-based day offset into
// month and day and applies the January/February year carry. Uses jdd_pkg, jdd_cdiv.
module jdd_month (
    input  logic                                i_clk,
    input  logic [jdd_pkg::MONTH_STAGES-1:0]    i_ld,
    input  jdd_pkg::t_era_item                  i_item,
    output jdd_pkg::t_date                      o_date
);

    logic [15:0]        r7_x80;
    jdd_pkg::t_era_item r7_item;
    logic [3:0]         r8_mo;
    jdd_pkg::t_era_item r8_item;
    logic [14:0]        r9_p;
    logic [3:0]         r9_month;
    logic [15:0]        r9_year;
    jdd_pkg::t_era_item r9_item;
    logic [8:0]         r10_q80;
    logic [3:0]         r10_month;
    logic [15:0]        r10_year;
    jdd_pkg::t_era_item r10_item;
    jdd_pkg::t_date     r11_date;

    logic [3:0]  n8_mo;
    logic        carry;
    logic [8:0]  n10_q80;
    logic [8:0]  day_full;

    // Stage 7: scale the day offset for the month division.
    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r7_x80  <= 16'd80 * {7'd0, i_item.doy};
            r7_item <= i_item;
        end
    end

    // Stage 8: month counted from March.
    jdd_cdiv #(.W(16), .C(2447), .QW(4)) u_div_month (
        .i_x (r7_x80),
        .o_q (n8_mo)
    );

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r8_mo   <= n8_mo;
            r8_item <= r7_item;
        end
    end

    // Stage 9: days before the month, and the carry for January and February.
    assign carry = (r8_mo >= 4'd11);

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r9_p     <= 15'd2447 * {11'd0, r8_mo};
            r9_month <= carry ? (r8_mo - 4'd10) : (r8_mo + 4'd2);
            r9_year  <= r8_item.year_base + {15'd0, carry};
            r9_item  <= r8_item;
        end
    end

    // Stage 10: scale the month start back to days.
    jdd_cdiv #(.W(15), .C(80), .QW(9)) u_div_start (
        .i_x (r9_p),
        .o_q (n10_q80)
    );

    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r10_q80   <= n10_q80;
            r10_month <= r9_month;
            r10_year  <= r9_year;
            r10_item  <= r9_item;
        end
    end

    // Stage 11: day of month; this is the output register.
    assign day_full = r10_item.doy - r10_q80;

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r11_date.year         <= r10_year;
            r11_date.month        <= r10_month;
            r11_date.day          <= day_full[4:0];
            r11_date.weekday      <= r10_item.weekday;
            r11_date.is_gregorian <= r10_item.is_gregorian;
        end
    end

    assign o_date = r11_date;

endmodule

### sv/julian_day_to_date_unit.sv
// Top level of the Julian day number to calendar date unit: stage handshake
// control around the jdd_era and jdd_month pipelines. Uses jdd_pkg.
//
//  Channel | Direction | Payload (lowest bits first)
//  --------+-----------+----------------------------------------------------
//  s       | in        | tdata: day_number[22:0], zero pad [23]
//  m       | out       | tdata: year[15:0], month[19:16], day[24:20],
//          |           |        weekday[27:25], zero pad [31:28]
//          |           | tuser: is_gregorian
//
// Each request passes through 11 register stages, 1 to 6 in jdd_era and 7 to 11 in
// jdd_month, and is offered from the stage 11 register. One request can be taken in
// every cycle unless every stage holds one while the output side stalls.
// The latency is set by the chain of constant divisions (cycles, year, month).
// Reset clears only the stage valid bits; payload registers are left as they are.
// A stall on the output side holds every full stage with no empty stage ahead of it
// and lets the others move on, so requests are taken until every stage holds one.
module julian_day_to_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // day_number[22:0], pad[23]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // year[15:0], month[19:16], day[24:20], weekday[27:25]
    output logic        o_m_tuser    // is_gregorian
);

    localparam int unsigned N  = jdd_pkg::PIPE_DEPTH;
    localparam int unsigned NE = jdd_pkg::ERA_STAGES;

    logic [N:1]          r_v;
    logic [N:1]          n_v;
    logic [N:1]          stage_en;
    logic [N:0]          v_in;
    jdd_pkg::t_era_item  era_item;
    jdd_pkg::t_date      date;

    // A stage may load when some stage from it to the output is empty,
    // or when the output is being taken.
    genvar k;
    generate
        for (k = 1; k <= N; k++) begin : g_en
            assign stage_en[k] = i_m_tready || !(&r_v[N:k]);
        end
    endgenerate

    // Valid bits move with the data.
    assign v_in = {r_v, i_s_tvalid};

    always_comb begin
        for (int s = 1; s <= N; s++) begin
            n_v[s] = stage_en[s] ? v_in[s-1] : r_v[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // Calendar-specific front end.
    jdd_era u_era (
        .i_clk        (i_clk),
        .i_ld         (stage_en[NE:1]),
        .i_day_number (i_s_tdata[jdd_pkg::DAY_W-1:0]),
        .o_item       (era_item)
    );

    // Shared month and day back end.
    jdd_month u_month (
        .i_clk  (i_clk),
        .i_ld   (stage_en[N:NE+1]),
        .i_item (era_item),
        .o_date (date)
    );

    // Ports.
    assign o_s_tready = stage_en[1];
    assign o_m_tvalid = r_v[N];
    assign o_m_tdata  = {4'd0, date.weekday, date.day, date.month, date.year};
    assign o_m_tuser  = date.is_gregorian;

    // Requests are refused only when every stage holds one.
    a_refuse_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v))
        else $error("input refused while a pipeline stage is empty");

    // A delivered date is well formed.
    a_date_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (date.month >= 4'd1 && date.month <= 4'd12 &&
                        date.day >= 5'd1 && date.day <= 5'd31 && date.weekday <= 3'd6))
        else $error("date field out of range");

    // The calendar flag agrees with the year of the switch.
    a_calendar_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (date.is_gregorian ? ($signed(date.year) >= 16'sd1582)
                                          : ($signed(date.year) <= 16'sd1582)))
        else $error("calendar flag does not match the year");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered straight after reset");

endmodule

### tb/sv/jdd_date_checker.sv
// Checker for the Julian day number to calendar date unit: watches both stream
// channels, predicts each date from the accepted day number and compares.
// Depends on jdd_pkg for the date layout and the calendar switch day.
module jdd_date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // day_number[22:0], pad[23]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // year[15:0], month[19:16], day[24:20], weekday[27:25]
    input  logic        i_m_tuser,   // is_gregorian
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_gregorian
);
    timeunit 1ns;
    timeprecision 1ps;

    // Dates still owed by the unit, oldest first.
    jdd_pkg::t_date owed_dates[$];
    int             mismatches = 0;
    int             checked    = 0;
    int             gregorian  = 0;
    int             owed_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = owed_count;
    assign o_checked    = checked;
    assign o_gregorian  = gregorian;

    // Civil date whose day begins at noon of the given Julian day number.
    function automatic jdd_pkg::t_date civil_date_of(input logic [jdd_pkg::DAY_W-1:0] jdn);
        longint         jd, rest, cent4, yr, mo, dd, carry, shifted, quad, yq;
        jdd_pkg::t_date date;
        jd = longint'(jdn);
        if (jdn >= jdd_pkg::SWITCH_DAY) begin
            // Gregorian: strip whole 400-year cycles, then years within them.
            rest  = jd + 68569;
            cent4 = (4 * rest) / 146097;
            rest  = rest - (146097 * cent4 + 3) / 4;
            yr    = (4000 * (rest + 1)) / 1461001;
            rest  = rest - (1461 * yr) / 4 + 31;
            mo    = (80 * rest) / 2447;
            dd    = rest - (2447 * mo) / 80;
            carry = mo / 11;
            yr    = 100 * (cent4 - 49) + yr + carry;
        end else begin
            // Julian: four-year cycles with the leap day at the end of each.
            shifted = jd + 1402;
            quad    = (shifted - 1) / 1461;
            rest    = shifted - 1461 * quad;
            yq      = (rest - 1) / 365 - rest / 1461;
            rest    = rest - 365 * yq + 30;
            mo      = (80 * rest) / 2447;
            dd      = rest - (2447 * mo) / 80;
            carry   = mo / 11;
            yr      = 4 * quad + yq + carry - 4716;
        end
        date.year         = 16'(yr);
        date.month        = 4'(mo + 2 - 12 * carry);
        date.day          = 5'(dd);
        date.weekday      = 3'((jd + 2) % 7);
        date.is_gregorian = (jdn >= jdd_pkg::SWITCH_DAY);
        return date;
    endfunction

    // One line per mismatch, and every mismatch counts.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Requests in are predicted first so that nothing is lost if both meet.
    always @(posedge i_clk) begin
        jdd_pkg::t_date want;
        jdd_pkg::t_date got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                owed_dates.push_back(civil_date_of(i_s_tdata[jdd_pkg::DAY_W-1:0]));
            if (i_m_tvalid && i_m_tready) begin
                got.year         = i_m_tdata[15:0];
                got.month        = i_m_tdata[19:16];
                got.day          = i_m_tdata[24:20];
                got.weekday      = i_m_tdata[27:25];
                got.is_gregorian = i_m_tuser;
                if (owed_dates.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting, tdata %h",
                                              i_m_tdata));
                end else begin
                    want = owed_dates.pop_front();
                    checked++;
                    if (want.is_gregorian)
                        gregorian++;
                    if (got.year !== want.year)
                        report_mismatch($sformatf("year %0d, expected %0d",
                                                  $signed(got.year), $signed(want.year)));
                    if (got.month !== want.month)
                        report_mismatch($sformatf("month %0d, expected %0d",
                                                  got.month, want.month));
                    if (got.day !== want.day)
                        report_mismatch($sformatf("day %0d, expected %0d",
                                                  got.day, want.day));
                    if (got.weekday !== want.weekday)
                        report_mismatch($sformatf("weekday %0d, expected %0d",
                                                  got.weekday, want.weekday));
                    if (got.is_gregorian !== want.is_gregorian)
                        report_mismatch($sformatf("calendar flag %b, expected %b",
                                                  got.is_gregorian, want.is_gregorian));
                end
            end
        end
        owed_count = owed_dates.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the testbench for the Julian day number to calendar date unit: clock,
// reset, day number stimulus, output back-pressure, watchdog and verdict.
// Depends on jdd_pkg, julian_day_to_date_unit and jdd_date_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_DAYS = 827;
    localparam int IDLE_LIMIT  = 2000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;
    int checked;
    int gregorian;
    int idle_cycles  = 0;
    bit sender_eager = 1'b0;

    always #4 clk = ~clk;

    julian_day_to_date_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    jdd_date_checker date_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_gregorian  (gregorian)
    );

    // Offer one day number after a random gap and hold it until it is taken.
    task automatic send_day(input logic [jdd_pkg::DAY_W-1:0] jdn);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, jdn};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    // Random day numbers, weighted towards the calendar switch, the modern era
    // and both ends of the range.
    function automatic logic [jdd_pkg::DAY_W-1:0] random_day();
        case ($urandom_range(0, 4))
            0: return jdd_pkg::DAY_W'($urandom());
            1: return jdd_pkg::SWITCH_DAY - 23'd3000 + 23'($urandom_range(0, 6000));
            2: return 23'($urandom_range(2200000, 2700000));
            3: return 23'($urandom_range(0, 4000));
            default: return 23'h7FFFFF - 23'($urandom_range(0, 4000));
        endcase
    endfunction

    // Output side: a random stall before each result, with eager stretches.
    initial begin
        int stall;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (taken % 64 == 0)
                eager = ($urandom_range(0, 3) == 0);
            stall = eager ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
            @(negedge clk);
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("No request moved for %0d cycles, %0d results outstanding.",
                     IDLE_LIMIT, pending);
            $display("julian_day_to_date_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, drain and verdict.
    initial begin
        logic [jdd_pkg::DAY_W-1:0] directed_days[$];
        directed_days = '{
            23'd0, 23'd1, 23'd365, 23'd1460, 23'd1461,
            // Calendar switch, a full week across it.
            23'd2299158, 23'd2299159, 23'd2299160, 23'd2299161,
            23'd2299162, 23'd2299163, 23'd2299164,
            // Turn of the year 0 to 1, 1900 without leap day, 2000 with one.
            23'd1721423, 23'd1721424, 23'd2415079, 23'd2415080,
            23'd2451544, 23'd2451545, 23'd2451604,
            // Largest day numbers and alternating bit patterns.
            23'h7FFFFE, 23'h7FFFFF, 23'h555555, 23'h2AAAAA
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_days[i])
            send_day(directed_days[i]);
        for (int n = 0; n < RANDOM_DAYS; n++) begin
            if (n % 64 == 0)
                sender_eager = ($urandom_range(0, 3) == 0);
            send_day(random_day());
        end
        s_tvalid <= 1'b0;

        // Drain: every result in, then a wait for stray results.
        while (pending != 0)
            @(posedge clk);
        repeat (jdd_pkg::PIPE_DEPTH + 4) @(posedge clk);

        $display("Converted %0d day numbers: %0d Gregorian dates, %0d Julian dates.",
                 checked, gregorian, checked - gregorian);
        $display("Gaps and stalls of up to 12 cycles on both channels, %0d mismatches.",
                 fail_count);
        if (fail_count == 0)
            $display("julian_day_to_date_unit verification clean");
        else
            $display("julian_day_to_date_unit verification failed");
        $finish;
    end

endmodule
